FILE: src/text_console_cursor_engine_top_macros.svh
// ----------------------------------------------------------------------------
// text console cursor engine - assertion macros
// shared property shorthands for the console engine checks
// ----------------------------------------------------------------------------
`ifndef TEXT_CONSOLE_CURSOR_ENGINE_TOP_MACROS_SVH
`define TEXT_CONSOLE_CURSOR_ENGINE_TOP_MACROS_SVH

// same-cycle implication, disabled during reset
`define TCC_ASSERT_NOW(label, ante, cons, msg) \
   label: assert property (@(posedge clock) disable iff (reset) (ante) |-> (cons)) \
      else $error(msg);

// next-cycle implication, disabled during reset
`define TCC_ASSERT_NEXT(label, ante, cons, msg) \
   label: assert property (@(posedge clock) disable iff (reset) (ante) |=> (cons)) \
      else $error(msg);

`endif

FILE: src/tcc_pkg.sv
// ----------------------------------------------------------------------------
// tcc_pkg
// types and constants of the text console cursor engine
// ----------------------------------------------------------------------------
package tcc_pkg;

   // grid defaults
   localparam int DEFAULT_COLUMNS = 80;
   localparam int DEFAULT_ROWS    = 25;

   // port field widths
   localparam int CMD_W       = 2;
   localparam int CHAR_W      = 8;
   localparam int ATTR_W      = 8;
   localparam int COLOR_W     = 4;
   localparam int CELL_W      = CHAR_W + ATTR_W;
   localparam int READ_COL_W  = 7;
   localparam int READ_ROW_W  = 5;
   localparam int CURSOR_COL_W = 7;
   localparam int CURSOR_ROW_W = 5;
   localparam int CSR_INDEX_W = 1;

   // register indexes
   localparam logic [CSR_INDEX_W-1:0] CSR_FG_COLOR = 1'd0;
   localparam logic [CSR_INDEX_W-1:0] CSR_BG_COLOR = 1'd1;

   localparam logic [COLOR_W-1:0] FG_COLOR_RESET = 4'd7;
   localparam logic [COLOR_W-1:0] BG_COLOR_RESET = 4'd0;

   // control bytes
   localparam logic [CHAR_W-1:0] CHAR_BACKSPACE = 8'h08;
   localparam logic [CHAR_W-1:0] CHAR_TAB       = 8'h09;
   localparam logic [CHAR_W-1:0] CHAR_NEWLINE   = 8'h0a;
   localparam logic [CHAR_W-1:0] CHAR_RETURN    = 8'h0d;
   localparam logic [CHAR_W-1:0] CHAR_SPACE     = 8'h20;

   localparam int TAB_STEP = 8;

   // cell content after power-up
   localparam logic [CELL_W-1:0] RESET_CELL = 16'h0720;

   typedef enum logic [CMD_W-1:0] {
      CMD_PUT   = 2'd0,
      CMD_CLEAR = 2'd1,
      CMD_READ  = 2'd2
   } cmd_type;

   typedef enum logic [4:0] {
      ST_IDLE   = 5'b00001,
      ST_MAP    = 5'b00010,
      ST_ACCESS = 5'b00100,
      ST_RDWAIT = 5'b01000,
      ST_SWEEP  = 5'b10000
   } state_type;

endpackage

FILE: src/text_console_cursor_engine_top.sv
// ----------------------------------------------------------------------------
// text_console_cursor_engine_top
// text-mode terminal: cell grid in one synchronous ram, cursor and scroll ring
// ----------------------------------------------------------------------------
//
//  channel   ports                                  handshake
//  --------  -------------------------------------  ------------------------------
//  request   req_cmd req_char_code req_read_column  start high while busy low
//            req_read_row
//  response  rsp_cell_char rsp_cell_attribute       rsp_strobe, one cycle a word
//            rsp_cursor_column rsp_cursor_row
//  csr       csr_write_en csr_index csr_wdata       write at every enabled edge
//
//  a word passes the row map, the ram access and the response register before
//  it is strobed; a read of a cell in the grid also waits on the ram read data
//  busy drops as the strobe rises, so a new word is taken only after the last is answered
//  a scroll adds one ram write per bottom-row cell, a clear one write per grid cell
//  after reset a sweep of every cell writes space / attribute 0x07 with busy held,
//  csr writes are taken meanwhile; the response side cannot stall
//
`include "text_console_cursor_engine_top_macros.svh"

module text_console_cursor_engine_top #(
   parameter int COLUMNS = tcc_pkg::DEFAULT_COLUMNS,
   parameter int ROWS    = tcc_pkg::DEFAULT_ROWS
) (
   input  logic                              clock,
   input  logic                              reset,
   // request
   input  logic                              start,
   output logic                              busy,
   input  logic [tcc_pkg::CMD_W-1:0]         req_cmd,
   input  logic [tcc_pkg::CHAR_W-1:0]        req_char_code,
   input  logic [tcc_pkg::READ_COL_W-1:0]    req_read_column,
   input  logic [tcc_pkg::READ_ROW_W-1:0]    req_read_row,
   // response
   output logic                              rsp_strobe,
   output logic [tcc_pkg::CHAR_W-1:0]        rsp_cell_char,
   output logic [tcc_pkg::ATTR_W-1:0]        rsp_cell_attribute,
   output logic [tcc_pkg::CURSOR_COL_W-1:0]  rsp_cursor_column,
   output logic [tcc_pkg::CURSOR_ROW_W-1:0]  rsp_cursor_row,
   // csr
   input  logic                              csr_write_en,
   input  logic [tcc_pkg::CSR_INDEX_W-1:0]   csr_index,
   input  logic [tcc_pkg::COLOR_W-1:0]       csr_wdata
);
   import tcc_pkg::*;

   localparam int CELLS  = COLUMNS * ROWS;
   localparam int ADDR_W = $clog2(CELLS);
   // column counter also holds a tab target past the right edge
   localparam int COL_W  = $clog2(COLUMNS + TAB_STEP);
   localparam int ROW_W  = $clog2(ROWS);

   // ------------------------------------------------------------------------
   // registers
   // ------------------------------------------------------------------------
   state_type                 state_ff, state_in;
   cmd_type                   cmd_ff, cmd_in;
   logic [CHAR_W-1:0]         code_ff, code_in;
   logic [READ_COL_W-1:0]     rcol_ff, rcol_in;
   logic [READ_ROW_W-1:0]     rrow_ff, rrow_in;

   // cursor in logical rows; top_ff is the ram row shown as screen row 0
   logic [COL_W-1:0]          cursor_col_ff, cursor_col_in;
   logic [ROW_W-1:0]          cursor_row_ff, cursor_row_in;
   logic [ROW_W-1:0]          top_ff, top_in;

   // ram row of the access, resolved in the row-map state ahead of the access
   logic [ROW_W-1:0]          phys_ff, phys_in;
   logic                      inrange_ff, inrange_in;

   // fill sweep
   logic [ADDR_W-1:0]         sweep_addr_ff, sweep_addr_in;
   logic [ADDR_W-1:0]         sweep_end_ff, sweep_end_in;
   logic [CELL_W-1:0]         sweep_data_ff, sweep_data_in;
   logic                      sweep_reply_ff, sweep_reply_in;

   logic [COLOR_W-1:0]        fg_ff, bg_ff;

   logic                      rsp_strobe_ff, rsp_strobe_in;
   logic [CHAR_W-1:0]         rsp_char_ff, rsp_char_in;
   logic [ATTR_W-1:0]         rsp_attr_ff, rsp_attr_in;
   logic [CURSOR_COL_W-1:0]   rsp_col_ff, rsp_col_in;
   logic [CURSOR_ROW_W-1:0]   rsp_row_ff, rsp_row_in;

   // ------------------------------------------------------------------------
   // cell ram: one write port, one read port, registered read data
   // ------------------------------------------------------------------------
   logic [CELL_W-1:0]         cells_mem [CELLS];
   logic                      mem_we, mem_re;
   logic [ADDR_W-1:0]         mem_waddr, mem_raddr;
   logic [CELL_W-1:0]         mem_wdata;
   logic [CELL_W-1:0]         rd_data_ff;

   always_ff @(posedge clock) begin
      if (mem_we) begin
         cells_mem[mem_waddr] <= mem_wdata;
      end
      if (mem_re) begin
         rd_data_ff <= cells_mem[mem_raddr];
      end
   end

   // ------------------------------------------------------------------------
   // helpers
   // ------------------------------------------------------------------------
   logic [ATTR_W-1:0]         attr;
   logic [CELL_W-1:0]         blank;
   logic [ROW_W-1:0]          row_sel;
   logic [ROW_W:0]            row_sum;
   logic [COL_W-1:0]          col_sel;
   logic [ADDR_W-1:0]         access_addr;
   logic [ADDR_W-1:0]         scroll_base;
   logic [COL_W-1:0]          tab_col;
   logic                      put_newline;

   assign attr  = {bg_ff, fg_ff};
   assign blank = {attr, CHAR_SPACE};

   // logical row to ram row, one subtract at most; an off-grid read row may exceed ROWS
   assign row_sel = (cmd_ff == CMD_READ) ? ROW_W'(rrow_ff) : cursor_row_ff;
   assign row_sum = {1'b0, row_sel} + {1'b0, top_ff};

   always_comb begin
      if (cmd_ff == CMD_READ) begin
         col_sel = COL_W'(rcol_ff);
      end else if (code_ff == CHAR_BACKSPACE) begin
         col_sel = cursor_col_ff - COL_W'(1);
      end else begin
         col_sel = cursor_col_ff;
      end
   end

   assign access_addr = ADDR_W'(phys_ff) * ADDR_W'(COLUMNS) + ADDR_W'(col_sel);
   // after a scroll the old top row becomes the bottom row
   assign scroll_base = ADDR_W'(top_ff) * ADDR_W'(COLUMNS);
   assign tab_col     = (cursor_col_ff + COL_W'(TAB_STEP)) & ~COL_W'(TAB_STEP - 1);

   // ------------------------------------------------------------------------
   // sequencer
   // ------------------------------------------------------------------------
   always_comb begin
      state_in       = state_ff;
      cmd_in         = cmd_ff;
      code_in        = code_ff;
      rcol_in        = rcol_ff;
      rrow_in        = rrow_ff;
      cursor_col_in  = cursor_col_ff;
      cursor_row_in  = cursor_row_ff;
      top_in         = top_ff;
      phys_in        = phys_ff;
      inrange_in     = inrange_ff;
      sweep_addr_in  = sweep_addr_ff;
      sweep_end_in   = sweep_end_ff;
      sweep_data_in  = sweep_data_ff;
      sweep_reply_in = sweep_reply_ff;
      rsp_strobe_in  = 1'b0;
      rsp_char_in    = rsp_char_ff;
      rsp_attr_in    = rsp_attr_ff;
      rsp_col_in     = rsp_col_ff;
      rsp_row_in     = rsp_row_ff;
      mem_we         = 1'b0;
      mem_waddr      = access_addr;
      mem_wdata      = blank;
      mem_re         = 1'b0;
      mem_raddr      = access_addr;
      put_newline    = 1'b0;

      unique case (state_ff)
         ST_IDLE: begin
            if (start) begin
               // unused command code falls through as a no-op with a reply
               cmd_in   = cmd_type'(req_cmd);
               code_in  = req_char_code;
               rcol_in  = req_read_column;
               rrow_in  = req_read_row;
               state_in = ST_MAP;
            end
         end

         ST_MAP: begin
            phys_in    = (row_sum >= (ROW_W+1)'(ROWS)) ?
                         ROW_W'(row_sum - (ROW_W+1)'(ROWS)) : ROW_W'(row_sum);
            inrange_in = (32'(rcol_ff) < COLUMNS) && (32'(rrow_ff) < ROWS);
            state_in   = ST_ACCESS;
         end

         ST_ACCESS: begin
            rsp_char_in   = '0;
            rsp_attr_in   = '0;
            rsp_strobe_in = 1'b1;
            state_in      = ST_IDLE;
            unique case (cmd_ff)
               CMD_PUT: begin
                  case (code_ff)
                     CHAR_NEWLINE: begin
                        put_newline = 1'b1;
                     end
                     CHAR_TAB: begin
                        cursor_col_in = tab_col;
                        put_newline   = (32'(tab_col) >= COLUMNS);
                     end
                     CHAR_RETURN: begin
                        cursor_col_in = '0;
                     end
                     CHAR_BACKSPACE: begin
                        // no-op at the left edge
                        if (cursor_col_ff != '0) begin
                           cursor_col_in = col_sel;
                           mem_we        = 1'b1;
                        end
                     end
                     default: begin
                        mem_we    = 1'b1;
                        mem_wdata = {attr, code_ff};
                        if (cursor_col_ff == COL_W'(COLUMNS - 1)) begin
                           put_newline = 1'b1;
                        end else begin
                           cursor_col_in = cursor_col_ff + COL_W'(1);
                        end
                     end
                  endcase
                  if (put_newline) begin
                     cursor_col_in = '0;
                     if (cursor_row_ff == ROW_W'(ROWS - 1)) begin
                        // scroll: rotate the ring and blank the new bottom row
                        top_in         = (top_ff == ROW_W'(ROWS - 1)) ?
                                         '0 : top_ff + ROW_W'(1);
                        sweep_addr_in  = scroll_base;
                        sweep_end_in   = scroll_base + ADDR_W'(COLUMNS - 1);
                        sweep_data_in  = blank;
                        sweep_reply_in = 1'b1;
                        rsp_strobe_in  = 1'b0;
                        state_in       = ST_SWEEP;
                     end else begin
                        cursor_row_in = cursor_row_ff + ROW_W'(1);
                     end
                  end
               end
               CMD_CLEAR: begin
                  cursor_col_in  = '0;
                  cursor_row_in  = '0;
                  top_in         = '0;
                  sweep_addr_in  = '0;
                  sweep_end_in   = ADDR_W'(CELLS - 1);
                  sweep_data_in  = blank;
                  sweep_reply_in = 1'b1;
                  rsp_strobe_in  = 1'b0;
                  state_in       = ST_SWEEP;
               end
               CMD_READ: begin
                  // cells outside the grid read as zero without a ram access
                  if (inrange_ff) begin
                     mem_re        = 1'b1;
                     rsp_strobe_in = 1'b0;
                     state_in      = ST_RDWAIT;
                  end
               end
               default: begin
               end
            endcase
         end

         ST_RDWAIT: begin
            rsp_char_in   = rd_data_ff[CHAR_W-1:0];
            rsp_attr_in   = rd_data_ff[CELL_W-1:CHAR_W];
            rsp_strobe_in = 1'b1;
            state_in      = ST_IDLE;
         end

         ST_SWEEP: begin
            mem_we    = 1'b1;
            mem_waddr = sweep_addr_ff;
            mem_wdata = sweep_data_ff;
            if (sweep_addr_ff == sweep_end_ff) begin
               rsp_strobe_in = sweep_reply_ff;
               state_in      = ST_IDLE;
            end else begin
               sweep_addr_in = sweep_addr_ff + ADDR_W'(1);
            end
         end

         default: begin
            state_in = ST_IDLE;
         end
      endcase

      if (rsp_strobe_in) begin
         rsp_col_in = CURSOR_COL_W'(cursor_col_in);
         rsp_row_in = CURSOR_ROW_W'(cursor_row_in);
      end
   end

   // ------------------------------------------------------------------------
   // control registers
   // ------------------------------------------------------------------------
   always_ff @(posedge clock) begin
      if (reset) begin
         // power-up fill of the whole ram, no reply word
         state_ff       <= ST_SWEEP;
         cursor_col_ff  <= '0;
         cursor_row_ff  <= '0;
         top_ff         <= '0;
         sweep_addr_ff  <= '0;
         sweep_end_ff   <= ADDR_W'(CELLS - 1);
         sweep_data_ff  <= RESET_CELL;
         sweep_reply_ff <= 1'b0;
         rsp_strobe_ff  <= 1'b0;
      end else begin
         state_ff       <= state_in;
         cursor_col_ff  <= cursor_col_in;
         cursor_row_ff  <= cursor_row_in;
         top_ff         <= top_in;
         sweep_addr_ff  <= sweep_addr_in;
         sweep_end_ff   <= sweep_end_in;
         sweep_data_ff  <= sweep_data_in;
         sweep_reply_ff <= sweep_reply_in;
         rsp_strobe_ff  <= rsp_strobe_in;
      end
   end

   // color registers
   always_ff @(posedge clock) begin
      if (reset) begin
         fg_ff <= FG_COLOR_RESET;
         bg_ff <= BG_COLOR_RESET;
      end else if (csr_write_en) begin
         unique case (csr_index)
            CSR_FG_COLOR: fg_ff <= csr_wdata;
            CSR_BG_COLOR: bg_ff <= csr_wdata;
            default: begin
            end
         endcase
      end
   end

   // payload registers
   always_ff @(posedge clock) begin
      cmd_ff      <= cmd_in;
      code_ff     <= code_in;
      rcol_ff     <= rcol_in;
      rrow_ff     <= rrow_in;
      phys_ff     <= phys_in;
      inrange_ff  <= inrange_in;
      rsp_char_ff <= rsp_char_in;
      rsp_attr_ff <= rsp_attr_in;
      rsp_col_ff  <= rsp_col_in;
      rsp_row_ff  <= rsp_row_in;
   end

   // ------------------------------------------------------------------------
   // outputs
   // ------------------------------------------------------------------------
   assign busy               = (state_ff != ST_IDLE);
   assign rsp_strobe         = rsp_strobe_ff;
   assign rsp_cell_char      = rsp_char_ff;
   assign rsp_cell_attribute = rsp_attr_ff;
   assign rsp_cursor_column  = rsp_col_ff;
   assign rsp_cursor_row     = rsp_row_ff;

   // ------------------------------------------------------------------------
   // assertions
   // ------------------------------------------------------------------------
   `TCC_ASSERT_NEXT(a_accept_maps, start && !busy, state_ff == ST_MAP,
                    "accepted word did not enter the row-map cycle")
   `TCC_ASSERT_NOW(a_cursor_in_grid, 1'b1,
                   (32'(cursor_col_ff) < COLUMNS) && (32'(cursor_row_ff) < ROWS)
                   && (32'(top_ff) < ROWS),
                   "cursor or ring top outside the grid")
   `TCC_ASSERT_NOW(a_sweep_bounds, state_ff == ST_SWEEP,
                   (sweep_addr_ff <= sweep_end_ff) && (32'(sweep_end_ff) < CELLS),
                   "fill sweep outside the ram")
   `TCC_ASSERT_NEXT(a_single_strobe, rsp_strobe_ff, !rsp_strobe_ff,
                    "two response words without a request between them")

endmodule

FILE: tb/tb_text_console_cursor_engine_top.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// tb_text_console_cursor_engine_top
// drives put, clear, read and unused commands into the console engine with
// random gaps, tracks the grid and cursor in a mirror, and checks every result
// word field by field, across several foreground / background color settings
// ----------------------------------------------------------------------------
module tb_text_console_cursor_engine_top;
   import tcc_pkg::*;

   localparam int COLS        = DEFAULT_COLUMNS;
   localparam int ROWS        = DEFAULT_ROWS;
   localparam int CELL_COUNT  = COLS * ROWS;
   localparam int ITEM_TARGET = 1350;
   localparam int PHASES      = 6;
   // a clear or the power-up sweep holds busy for a full grid pass, so the
   // quiet limit is many grid passes long
   localparam int STALL_LIMIT = 20 * CELL_COUNT;
   localparam int TAIL_CYCLES = 16;
   localparam int REPORT_CAP  = 40;

   // command code the engine must answer without touching its state
   localparam logic [CMD_W-1:0] CMD_UNUSED = 2'd3;

   // one result word as the engine reports it
   typedef struct packed {
      logic [CHAR_W-1:0]       glyph;
      logic [ATTR_W-1:0]       attr;
      logic [CURSOR_COL_W-1:0] col;
      logic [CURSOR_ROW_W-1:0] row;
   } console_word_type;

   // mirror of the grid, cursor and colors, plus the words still owed
   class console_mirror;
      logic [CELL_W-1:0]  cells [CELL_COUNT];
      int                 col;
      int                 row;
      logic [COLOR_W-1:0] fg;
      logic [COLOR_W-1:0] bg;
      console_word_type   pending_words[$];
      int                 mismatches;
      int                 words_checked;
      int                 clears;
      int                 reads;
      int                 scrolls;

      function new();
         foreach (cells[i]) cells[i] = RESET_CELL;
         col           = 0;
         row           = 0;
         fg            = FG_COLOR_RESET;
         bg            = BG_COLOR_RESET;
         mismatches    = 0;
         words_checked = 0;
         clears        = 0;
         reads         = 0;
         scrolls       = 0;
      endfunction

      function logic [CELL_W-1:0] blank();
         return {bg, fg, CHAR_SPACE};
      endfunction

      function void set_color(logic [CSR_INDEX_W-1:0] idx, logic [COLOR_W-1:0] value);
         if (idx == CSR_FG_COLOR) fg = value;
         else bg = value;
      endfunction

      // column 0 of the next row, scrolling the grid below the last row
      function void line_feed();
         int i;
         col = 0;
         row++;
         if (row >= ROWS) begin
            for (i = 0; i < CELL_COUNT - COLS; i++) cells[i] = cells[i + COLS];
            for (i = CELL_COUNT - COLS; i < CELL_COUNT; i++) cells[i] = blank();
            row = ROWS - 1;
            scrolls++;
         end
      endfunction

      function void put_glyph(logic [CHAR_W-1:0] code);
         case (code)
            CHAR_NEWLINE: line_feed();
            CHAR_TAB: begin
               col = (col + TAB_STEP) & ~(TAB_STEP - 1);
               if (col >= COLS) line_feed();
            end
            CHAR_RETURN: col = 0;
            CHAR_BACKSPACE: begin
               if (col > 0) begin
                  col--;
                  cells[row * COLS + col] = blank();
               end
            end
            default: begin
               cells[row * COLS + col] = {bg, fg, code};
               col++;
               if (col >= COLS) line_feed();
            end
         endcase
      endfunction

      function void note_command(logic [CMD_W-1:0] cmd, logic [CHAR_W-1:0] code,
                                 logic [READ_COL_W-1:0] rc, logic [READ_ROW_W-1:0] rr);
         console_word_type w;
         w = '0;
         case (cmd)
            CMD_PUT: put_glyph(code);
            CMD_CLEAR: begin
               foreach (cells[i]) cells[i] = blank();
               col = 0;
               row = 0;
               clears++;
            end
            CMD_READ: begin
               reads++;
               if (rc < COLS && rr < ROWS) {w.attr, w.glyph} = cells[rr * COLS + rc];
            end
            default: ;
         endcase
         w.col = col[CURSOR_COL_W-1:0];
         w.row = row[CURSOR_ROW_W-1:0];
         pending_words.push_back(w);
      endfunction

      function void flag(string field, int expected, int actual);
         mismatches++;
         if (mismatches <= REPORT_CAP)
            $display("%0t: %s mismatch, expected 0x%0h actual 0x%0h",
                     $time, field, expected, actual);
         else if (mismatches == REPORT_CAP + 1)
            $display("%0t: further mismatches counted but not shown", $time);
      endfunction

      function void check_word(console_word_type got);
         console_word_type want;
         words_checked++;
         if (pending_words.size() == 0) begin
            flag("unexpected word", 0, int'(got));
         end else begin
            want = pending_words.pop_front();
            if (want.glyph != got.glyph)
               flag("cell_char", int'(want.glyph), int'(got.glyph));
            if (want.attr != got.attr)
               flag("cell_attribute", int'(want.attr), int'(got.attr));
            if (want.col != got.col)
               flag("cursor_column", int'(want.col), int'(got.col));
            if (want.row != got.row)
               flag("cursor_row", int'(want.row), int'(got.row));
         end
      endfunction
   endclass

   logic                    clock;
   logic                    reset;
   logic                    start;
   logic                    busy;
   logic [CMD_W-1:0]        req_cmd;
   logic [CHAR_W-1:0]       req_char_code;
   logic [READ_COL_W-1:0]   req_read_column;
   logic [READ_ROW_W-1:0]   req_read_row;
   logic                    rsp_strobe;
   logic [CHAR_W-1:0]       rsp_cell_char;
   logic [ATTR_W-1:0]       rsp_cell_attribute;
   logic [CURSOR_COL_W-1:0] rsp_cursor_column;
   logic [CURSOR_ROW_W-1:0] rsp_cursor_row;
   logic                    csr_write_en;
   logic [CSR_INDEX_W-1:0]  csr_index;
   logic [COLOR_W-1:0]      csr_wdata;

   console_mirror mirror;
   int            words_sent;
   int            color_writes;
   int            quiet_cycles;
   bit            steady;

   text_console_cursor_engine_top u_top (
      .clock              (clock),
      .reset              (reset),
      .start              (start),
      .busy               (busy),
      .req_cmd            (req_cmd),
      .req_char_code      (req_char_code),
      .req_read_column    (req_read_column),
      .req_read_row       (req_read_row),
      .rsp_strobe         (rsp_strobe),
      .rsp_cell_char      (rsp_cell_char),
      .rsp_cell_attribute (rsp_cell_attribute),
      .rsp_cursor_column  (rsp_cursor_column),
      .rsp_cursor_row     (rsp_cursor_row),
      .csr_write_en       (csr_write_en),
      .csr_index          (csr_index),
      .csr_wdata          (csr_wdata)
   );

   // 12 ns clock
   initial clock = 1'b0;
   always #6 clock = ~clock;

   // every strobed word is checked against the oldest owed word
   always @(posedge clock) begin
      if (!reset && rsp_strobe)
         mirror.check_word({rsp_cell_char, rsp_cell_attribute,
                            rsp_cursor_column, rsp_cursor_row});
   end

   // watchdog: any accepted command or result word restarts the count
   always @(posedge clock) begin
      if (reset || (start && !busy) || rsp_strobe) begin
         quiet_cycles <= 0;
      end else if (quiet_cycles >= STALL_LIMIT) begin
         $display("%0t: no progress for %0d cycles", $time, quiet_cycles);
         $display("Simulation FAILED");
         $finish;
      end else begin
         quiet_cycles <= quiet_cycles + 1;
      end
   end

   // one command word: random gap, then hold start until busy is seen low
   // at a rising edge; start stays high when the next word follows at once
   task automatic send_command(input logic [CMD_W-1:0] cmd, input logic [CHAR_W-1:0] code,
                               input logic [READ_COL_W-1:0] rc,
                               input logic [READ_ROW_W-1:0] rr);
      int gap;
      // occasional switch between gap-free stretches and random gaps
      if ($urandom_range(0, 39) == 0) steady = !steady;
      gap = steady ? 0 : int'($urandom_range(0, 6));
      @(negedge clock);
      if (gap > 0) begin
         start <= 1'b0;
         repeat (gap) @(negedge clock);
      end
      start           <= 1'b1;
      req_cmd         <= cmd;
      req_char_code   <= code;
      req_read_column <= rc;
      req_read_row    <= rr;
      do @(posedge clock); while (busy);
      mirror.note_command(cmd, code, rc, rr);
      words_sent++;
   endtask

   // unused fields carry random bits, the engine must ignore them
   task automatic put_char(input logic [CHAR_W-1:0] code);
      send_command(CMD_PUT, code, READ_COL_W'($urandom_range(0, 127)),
                   READ_ROW_W'($urandom_range(0, 31)));
   endtask

   task automatic read_cell(input logic [READ_COL_W-1:0] rc, input logic [READ_ROW_W-1:0] rr);
      send_command(CMD_READ, CHAR_W'($urandom_range(0, 255)), rc, rr);
   endtask

   // lower start and wait until every owed word has come back
   task automatic drain();
      @(negedge clock);
      start <= 1'b0;
      while (mirror.pending_words.size() != 0) @(posedge clock);
   endtask

   // both color registers, written back to back while the engine is idle
   task automatic set_colors(input logic [COLOR_W-1:0] fg, input logic [COLOR_W-1:0] bg);
      @(negedge clock);
      csr_write_en <= 1'b1;
      csr_index    <= CSR_FG_COLOR;
      csr_wdata    <= fg;
      @(negedge clock);
      csr_index    <= CSR_BG_COLOR;
      csr_wdata    <= bg;
      @(negedge clock);
      csr_write_en <= 1'b0;
      mirror.set_color(CSR_FG_COLOR, fg);
      mirror.set_color(CSR_BG_COLOR, bg);
      color_writes++;
   endtask

   initial begin
      int                 phase_end;
      int                 pick;
      int                 n;
      int                 term;
      int                 r;
      logic [CHAR_W-1:0]  glyph;
      logic [COLOR_W-1:0] fgv;
      logic [COLOR_W-1:0] bgv;

      mirror          = new();
      words_sent      = 0;
      color_writes    = 0;
      quiet_cycles    = 0;
      steady          = 1'b0;
      reset           = 1'b1;
      start           = 1'b0;
      req_cmd         = CMD_PUT;
      req_char_code   = '0;
      req_read_column = '0;
      req_read_row    = '0;
      csr_write_en    = 1'b0;
      csr_index       = CSR_FG_COLOR;
      csr_wdata       = '0;

      // synchronous reset, released at a falling edge
      repeat (2) @(posedge clock);
      @(negedge clock);
      reset <= 1'b0;

      // directed part, reset colors; the first word waits out the power-up sweep
      // corners of the grid still hold the power-up cell
      read_cell('0, '0);
      read_cell(READ_COL_W'(COLS - 1), READ_ROW_W'(ROWS - 1));
      // reads past the right edge, past the bottom, and of the widest field values
      read_cell(READ_COL_W'(COLS), '0);
      read_cell('0, READ_ROW_W'(ROWS));
      read_cell(7'h7f, 5'h1f);
      // unused command code with all fields high
      send_command(CMD_UNUSED, 8'hff, 7'h7f, 5'h1f);
      // backspace at column 0 does nothing
      put_char(CHAR_BACKSPACE);
      // plain byte, lowest and highest byte values
      put_char(8'h41);
      put_char(8'h00);
      put_char(8'hff);
      // backspace blanks the cell it steps back onto
      put_char(CHAR_BACKSPACE);
      put_char(CHAR_TAB);
      put_char(CHAR_RETURN);
      put_char(CHAR_NEWLINE);
      read_cell(7'd0, 5'd0);
      read_cell(7'd1, 5'd0);
      read_cell(7'd2, 5'd0);
      // clear with random field bits, then look at the home cell
      send_command(CMD_CLEAR, CHAR_W'($urandom_range(0, 255)),
                   READ_COL_W'($urandom_range(0, 127)), READ_ROW_W'($urandom_range(0, 31)));
      read_cell('0, '0);
      drain();

      // random part in phases, each with its own color setting
      for (int p = 0; p < PHASES; p++) begin
         case (p)
            0: begin fgv = 4'hf; bgv = 4'hf; end
            1: begin fgv = 4'h0; bgv = 4'h0; end
            2: begin fgv = 4'h0; bgv = 4'hf; end
            3: begin fgv = 4'hf; bgv = 4'h0; end
            default: begin
               fgv = COLOR_W'($urandom_range(0, 15));
               bgv = COLOR_W'($urandom_range(0, 15));
            end
         endcase
         set_colors(fgv, bgv);
         phase_end = ITEM_TARGET * (p + 1) / PHASES;
         while (words_sent < phase_end) begin
            pick = int'($urandom_range(0, 99));
            if (pick < 40) begin
               // a line of text, now and then long enough to wrap
               n = ($urandom_range(0, 9) == 0) ? int'($urandom_range(70, 90))
                                               : int'($urandom_range(1, 20));
               repeat (n) begin
                  if ($urandom_range(0, 4) == 0) glyph = CHAR_W'($urandom_range(0, 255));
                  else glyph = CHAR_W'($urandom_range(8'h20, 8'h7e));
                  put_char(glyph);
               end
               term = int'($urandom_range(0, 99));
               if (term < 60) begin
                  put_char(CHAR_NEWLINE);
               end else if (term < 75) begin
                  put_char(CHAR_RETURN);
                  put_char(CHAR_NEWLINE);
               end else if (term < 85) begin
                  put_char(CHAR_RETURN);
               end
            end else if (pick < 50) begin
               // newline bursts, the long ones can force scrolling
               n = ($urandom_range(0, 7) == 0) ? int'($urandom_range(20, 30))
                                               : int'($urandom_range(1, 6));
               repeat (n) put_char(CHAR_NEWLINE);
            end else if (pick < 58) begin
               // tab runs, the longest ones wrap at the right edge
               repeat ($urandom_range(1, 12)) put_char(CHAR_TAB);
            end else if (pick < 65) begin
               repeat ($urandom_range(1, 6)) put_char(CHAR_BACKSPACE);
            end else if (pick < 83) begin
               // reads: mostly near the cursor where text lands
               repeat ($urandom_range(1, 4)) begin
                  r = int'($urandom_range(0, 99));
                  if (r < 60)
                     read_cell(READ_COL_W'($urandom_range(0, COLS - 1)),
                               READ_ROW_W'((mirror.row > 0 && r < 25) ? mirror.row - 1
                                                                      : mirror.row));
                  else if (r < 85)
                     read_cell(READ_COL_W'($urandom_range(0, COLS - 1)),
                               READ_ROW_W'($urandom_range(0, ROWS - 1)));
                  else
                     read_cell(READ_COL_W'($urandom_range(0, 127)),
                               READ_ROW_W'($urandom_range(0, 31)));
               end
            end else if (pick < 86) begin
               send_command(CMD_CLEAR, CHAR_W'($urandom_range(0, 255)),
                            READ_COL_W'($urandom_range(0, 127)),
                            READ_ROW_W'($urandom_range(0, 31)));
            end else if (pick < 88) begin
               send_command(CMD_UNUSED, CHAR_W'($urandom_range(0, 255)),
                            READ_COL_W'($urandom_range(0, 127)),
                            READ_ROW_W'($urandom_range(0, 31)));
            end else begin
               // noise: any command with any field bits
               repeat ($urandom_range(1, 4))
                  send_command(CMD_W'($urandom_range(0, 3)), CHAR_W'($urandom_range(0, 255)),
                               READ_COL_W'($urandom_range(0, 127)),
                               READ_ROW_W'($urandom_range(0, 31)));
            end
         end
         drain();
      end

      // let a stray late word show up before judging
      repeat (TAIL_CYCLES) @(posedge clock);

      $display("covered %0d commands: %0d reads, %0d clears, %0d scrolls, %0d color settings",
               words_sent, mirror.reads, mirror.clears, mirror.scrolls, color_writes);
      $display("%0d result words checked, %0d field mismatches, %0d words still owed",
               mirror.words_checked, mirror.mismatches, mirror.pending_words.size());
      if (mirror.mismatches == 0 && mirror.pending_words.size() == 0)
         $display("Simulation PASSED");
      else
         $display("Simulation FAILED");
      $finish;
   end

endmodule
